[rtl/core/ppq_pkg.sv]
// ----------------------------------------------------------------------------
// ppq_pkg
// Shared constants, types and helpers of the preemptive priority ready queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppq_pkg;

    // Sizing
    localparam int READY_DEPTH = 32;
    localparam int PROC_IDS    = 64;
    localparam int PRIO_BITS   = 8;

    // Fixed field widths of the stream payload
    localparam int ID_W      = 6;
    localparam int PRIO_IN_W = 8;
    localparam int COUNT_W   = 6;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    // Derived widths
    localparam int PRIO_W  = (PRIO_BITS < PRIO_IN_W) ? PRIO_BITS : PRIO_IN_W;
    localparam int IDX_W   = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
    localparam int FILL_W  = $clog2(READY_DEPTH + 1);
    localparam int SLOT_W  = (PROC_IDS > 1) ? $clog2(PROC_IDS) : 1;
    localparam int TOTAL_W = $clog2(PROC_IDS + 1);

    typedef enum logic [1:0] {
        OP_NEW   = 2'd0,
        OP_READY = 2'd1,
        OP_TERM  = 2'd2,
        OP_POP   = 2'd3
    } op_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic term_step;
        logic pop_step;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  in_op;
        logic fill_zero;
        logic scan_end;
    } dp_status_t;

    // Map a process id onto its slot in the known-process map (id modulo PROC_IDS)
    function automatic logic [SLOT_W-1:0] map_slot(input logic [ID_W-1:0] id);
        logic [SLOT_W-1:0] slot;
        slot = '0;
        for (int k = 0; k < (1 << ID_W); k++)
        begin
            if (id == ID_W'(k))
            begin
                slot = SLOT_W'(k % PROC_IDS);
            end
        end
        return slot;
    endfunction

endpackage

[rtl/core/ppq_ctrl.sv]
// ----------------------------------------------------------------------------
// ppq_ctrl
// Sequencer of the ready queue: accepts requests, steps the scans of
// terminate and pop, and owns the result handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  ppq_pkg::dp_status_t status,
    output ppq_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_TERM = 3'b010,
        ST_POP  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   accept;

    // Take a request only when the result slot is free or drains this cycle
    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd.accept    = accept;
        cmd.term_step = (state_reg == ST_TERM);
        cmd.pop_step  = (state_reg == ST_POP);
    end

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (status.in_op)
                        ppq_pkg::OP_TERM:
                        begin
                            state_next = ST_TERM;
                        end
                        ppq_pkg::OP_POP:
                        begin
                            if (status.fill_zero)
                            begin
                                m_tvalid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_POP;
                            end
                        end
                        default:
                        begin
                            m_tvalid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_TERM, ST_POP:
            begin
                if (status.scan_end)
                begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

[rtl/core/ppq_datapath.sv]
// ----------------------------------------------------------------------------
// ppq_datapath
// Ready table in arrival order, known-process map and counters, scan
// registers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppq_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ppq_pkg::dp_cmd_t                  cmd,
    input  logic [ppq_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [1:0]                        s_tuser,
    output ppq_pkg::dp_status_t               status,
    output logic [ppq_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int DEPTH = ppq_pkg::READY_DEPTH;

    // Ready table
    logic [ppq_pkg::ID_W-1:0]     ids_reg   [DEPTH];
    logic [ppq_pkg::ID_W-1:0]     ids_next  [DEPTH];
    logic [ppq_pkg::PRIO_W-1:0]   prios_reg [DEPTH];
    logic [ppq_pkg::PRIO_W-1:0]   prios_next[DEPTH];
    logic [ppq_pkg::FILL_W-1:0]   fill_reg;
    logic [ppq_pkg::FILL_W-1:0]   fill_next;

    // Known processes
    logic [ppq_pkg::PROC_IDS-1:0] known_reg;
    logic [ppq_pkg::PROC_IDS-1:0] known_next;
    logic [ppq_pkg::TOTAL_W-1:0]  total_reg;
    logic [ppq_pkg::TOTAL_W-1:0]  total_next;

    // Scan state
    logic [ppq_pkg::ID_W-1:0]     id_reg;
    logic [ppq_pkg::ID_W-1:0]     id_next;
    logic [ppq_pkg::FILL_W-1:0]   idx_reg;
    logic [ppq_pkg::FILL_W-1:0]   idx_next;
    logic [ppq_pkg::IDX_W-1:0]    best_idx_reg;
    logic [ppq_pkg::IDX_W-1:0]    best_idx_next;
    logic [ppq_pkg::PRIO_W-1:0]   best_prio_reg;
    logic [ppq_pkg::PRIO_W-1:0]   best_prio_next;
    logic [ppq_pkg::ID_W-1:0]     best_id_reg;
    logic [ppq_pkg::ID_W-1:0]     best_id_next;

    // Result register
    logic                         preempt_reg;
    logic                         dv_reg;
    logic [ppq_pkg::ID_W-1:0]     did_reg;
    logic [ppq_pkg::COUNT_W-1:0]  count_reg;
    logic                         empty_reg;
    logic                         ovf_reg;

    // Request fields
    ppq_pkg::op_t                 in_op;
    logic [ppq_pkg::ID_W-1:0]     in_id;
    logic [ppq_pkg::PRIO_W-1:0]   in_prio;
    logic                         in_starts;
    logic                         in_run_v;
    logic [ppq_pkg::ID_W-1:0]     in_run_id;
    logic [ppq_pkg::PRIO_W-1:0]   in_run_prio;
    logic [ppq_pkg::SLOT_W-1:0]   in_slot;

    // Step controls
    logic                         scan_end;
    logic [ppq_pkg::ID_W-1:0]     rd_id;
    logic [ppq_pkg::PRIO_W-1:0]   rd_prio;
    logic                         do_insert;
    logic [ppq_pkg::ID_W-1:0]     ins_id;
    logic [ppq_pkg::PRIO_W-1:0]   ins_prio;
    logic                         do_remove;
    logic [ppq_pkg::IDX_W-1:0]    rm_pos;
    logic                         res_load;
    logic                         res_preempt;
    logic                         res_dv;
    logic [ppq_pkg::ID_W-1:0]     res_did;
    logic                         res_ovf;

    assign in_op       = ppq_pkg::op_t'(s_tuser);
    assign in_id       = s_tdata[5:0];
    assign in_prio     = s_tdata[6 +: ppq_pkg::PRIO_W];
    assign in_starts   = s_tdata[14];
    assign in_run_v    = s_tdata[15];
    assign in_run_id   = s_tdata[21:16];
    assign in_run_prio = s_tdata[22 +: ppq_pkg::PRIO_W];
    assign in_slot     = ppq_pkg::map_slot(in_id);

    assign scan_end = (idx_reg >= fill_reg);
    assign rd_id    = ids_reg[idx_reg[ppq_pkg::IDX_W-1:0]];
    assign rd_prio  = prios_reg[idx_reg[ppq_pkg::IDX_W-1:0]];

    always_comb
    begin
        status.in_op     = in_op;
        status.fill_zero = (fill_reg == '0);
        status.scan_end  = scan_end;
    end

    always_comb
    begin
        ids_next       = ids_reg;
        prios_next     = prios_reg;
        fill_next      = fill_reg;
        known_next     = known_reg;
        total_next     = total_reg;
        id_next        = id_reg;
        idx_next       = idx_reg;
        best_idx_next  = best_idx_reg;
        best_prio_next = best_prio_reg;
        best_id_next   = best_id_reg;
        do_insert      = 1'b0;
        ins_id         = in_id;
        ins_prio       = in_prio;
        do_remove      = 1'b0;
        rm_pos         = '0;
        res_load       = 1'b0;
        res_preempt    = 1'b0;
        res_dv         = 1'b0;
        res_did        = '0;
        res_ovf        = 1'b0;

        if (cmd.accept)
        begin
            id_next = in_id;
            unique case (in_op)
                ppq_pkg::OP_NEW:
                begin
                    if (!known_reg[in_slot])
                    begin
                        known_next[in_slot] = 1'b1;
                        total_next          = total_reg + ppq_pkg::TOTAL_W'(1);
                    end
                    do_insert = in_starts;
                    res_load  = 1'b1;
                end
                ppq_pkg::OP_READY:
                begin
                    // Preempt only a strictly lower running priority; queue the loser
                    if (in_run_v && (in_prio > in_run_prio))
                    begin
                        res_preempt = 1'b1;
                        res_dv      = 1'b1;
                        res_did     = in_id;
                        ins_id      = in_run_id;
                        ins_prio    = in_run_prio;
                    end
                    do_insert = 1'b1;
                    res_load  = 1'b1;
                end
                ppq_pkg::OP_TERM:
                begin
                    if (known_reg[in_slot])
                    begin
                        known_next[in_slot] = 1'b0;
                        total_next          = total_reg - ppq_pkg::TOTAL_W'(1);
                    end
                    idx_next = '0;
                end
                ppq_pkg::OP_POP:
                begin
                    if (fill_reg == '0)
                    begin
                        res_load = 1'b1;
                    end
                    else
                    begin
                        best_idx_next  = '0;
                        best_prio_next = prios_reg[0];
                        best_id_next   = ids_reg[0];
                        idx_next       = ppq_pkg::FILL_W'(1);
                    end
                end
                default:
                begin
                    res_load = 1'b0;
                end
            endcase
        end

        if (cmd.term_step)
        begin
            if (scan_end)
            begin
                res_load = 1'b1;
            end
            else if (rd_id == id_reg)
            begin
                // Hold the index: the next entry slides into this place
                do_remove = 1'b1;
                rm_pos    = idx_reg[ppq_pkg::IDX_W-1:0];
            end
            else
            begin
                idx_next = idx_reg + ppq_pkg::FILL_W'(1);
            end
        end

        if (cmd.pop_step)
        begin
            if (scan_end)
            begin
                res_dv    = 1'b1;
                res_did   = best_id_reg;
                do_remove = 1'b1;
                rm_pos    = best_idx_reg;
                res_load  = 1'b1;
            end
            else
            begin
                // Strictly greater keeps the oldest among equals
                if (rd_prio > best_prio_reg)
                begin
                    best_idx_next  = idx_reg[ppq_pkg::IDX_W-1:0];
                    best_prio_next = rd_prio;
                    best_id_next   = rd_id;
                end
                idx_next = idx_reg + ppq_pkg::FILL_W'(1);
            end
        end

        if (do_insert)
        begin
            if (fill_reg < ppq_pkg::FILL_W'(DEPTH))
            begin
                for (int j = 0; j < DEPTH; j++)
                begin
                    if (fill_reg == ppq_pkg::FILL_W'(j))
                    begin
                        ids_next[j]   = ins_id;
                        prios_next[j] = ins_prio;
                    end
                end
                fill_next = fill_reg + ppq_pkg::FILL_W'(1);
            end
            else
            begin
                res_ovf = 1'b1;
            end
        end

        if (do_remove)
        begin
            for (int j = 0; j < DEPTH - 1; j++)
            begin
                if (ppq_pkg::IDX_W'(j) >= rm_pos)
                begin
                    ids_next[j]   = ids_reg[j + 1];
                    prios_next[j] = prios_reg[j + 1];
                end
            end
            fill_next = fill_reg - ppq_pkg::FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            known_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            known_reg <= known_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ids_reg       <= ids_next;
        prios_reg     <= prios_next;
        id_reg        <= id_next;
        idx_reg       <= idx_next;
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
        best_id_reg   <= best_id_next;
        if (res_load)
        begin
            preempt_reg <= res_preempt;
            dv_reg      <= res_dv;
            did_reg     <= res_did;
            count_reg   <= ppq_pkg::COUNT_W'(fill_next);
            empty_reg   <= (total_next == '0);
            ovf_reg     <= res_ovf;
        end
    end

    assign m_tdata = {ovf_reg, empty_reg, count_reg, did_reg, dv_reg, preempt_reg};

endmodule

[rtl/core/preemptive_priority_ready_queue_core.sv]
// New, ready and pop on an empty table give their result in the cycle after the request
// is taken; pop and terminate give theirs once the scan of the N ready entries ends.
// Throughput: one request at a time; the ready-table scan, one entry a cycle, sets the
// pace of pop and terminate. A new request is taken while the previous result is being
// taken. Reset empties the table, clears the known-process map and drops any pending
// result.
// ----------------------------------------------------------------------------
// preemptive_priority_ready_queue_core
// Preemptive priority ready queue: stream requests in, one result per request out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module preemptive_priority_ready_queue_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // proc_id[5:0], priority_req[13:6], starts_ready[14], running_valid[15],
    // running_id[21:16], running_priority[29:22], zero[31:30]
    input  logic [ppq_pkg::IN_DATA_W-1:0]     s_tdata,
    // operation[1:0]
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // preempt[0], dispatch_valid[1], dispatch_id[7:2], ready_count[13:8],
    // known_empty[14], overflow[15]
    output logic [ppq_pkg::OUT_DATA_W-1:0]    m_tdata
);

    ppq_pkg::dp_cmd_t    cmd;
    ppq_pkg::dp_status_t status;

    ppq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ppq_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .status  (status),
        .m_tdata (m_tdata)
    );

endmodule
